/* sv/rgsv_pkg.sv */
// ----------------------------------------------------------------------------
// Ramped-gain stereo volume: shared types and constants
// Register indexes, configuration bundle, item classes, queue entry and
// back-end sequencer states.
// ----------------------------------------------------------------------------
package rgsv_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 32;
  localparam int STEP_W   = 33;
  localparam int FLEN_W   = 9;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 3;

  // 0.707 in Q1.15.
  localparam logic signed [15:0] MONO_COEF = 16'sd23167;
  // Unity gain in Q4.28.
  localparam logic [GAIN_W-1:0] UNITY_GAIN = 32'h1000_0000;

  typedef enum logic [IDX_W-1:0] {
    REG_ENABLE      = 3'd0,
    REG_MONO        = 3'd1,
    REG_CHANNELS    = 3'd2,
    REG_MUTE        = 3'd3,
    REG_GAIN_LINEAR = 3'd4,
    REG_FRAME_LEN   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic              enable;
    logic              mono;
    logic [1:0]        channels;
    logic              mute;
    logic [15:0]       gain_linear;
    logic [FLEN_W-1:0] frame_len;
  } cfg_t;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_SINGLE,
    MODE_STEREO,
    MODE_SUM
  } mode_t;

  // Operand a is the left sample or the premultiplied mono sum; b is the right sample.
  typedef struct packed {
    mode_t                      mode;
    logic signed [31:0]         a;
    logic signed [SAMPLE_W-1:0] b;
  } entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_STEP,
    B_MUL_LO,
    B_MUL_HI,
    B_RND,
    B_SAT,
    B_DONE
  } back_state_t;

endpackage

/* sv/rgsv_in_if.sv */
// ----------------------------------------------------------------------------
// Sample pair channel
// Valid/ready channel carrying one left/right sample pair per transfer.
// ----------------------------------------------------------------------------
interface rgsv_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

/* sv/rgsv_out_if.sv */
// ----------------------------------------------------------------------------
// Scaled sample channel
// Valid/ready channel carrying one scaled pair and the end-of-frame flag.
// ----------------------------------------------------------------------------
interface rgsv_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;
  logic               frame_done;

  modport source (output valid, output left_out, output right_out, output frame_done,
                  input ready);
  modport sink   (input valid, input left_out, input right_out, input frame_done,
                  output ready);
endinterface

/* sv/rgsv_front.sv */
// ----------------------------------------------------------------------------
// Front end
// Accepts sample pairs, classifies them by mode and forms the mono sum
// product before handing them to the queue.
// ----------------------------------------------------------------------------
module rgsv_front (
  rgsv_in_if.sink           in_chan,
  input  rgsv_pkg::cfg_t    cfg,
  input  logic              q_ready,
  output logic              q_push,
  output rgsv_pkg::entry_t  q_entry
);

  logic               two_ch;
  logic signed [16:0] pair_sum;
  logic signed [32:0] mono_prod;

  assign in_chan.ready = q_ready;
  assign q_push        = in_chan.valid && q_ready;

  assign two_ch    = (cfg.channels == 2'd2);
  assign pair_sum  = 17'(in_chan.left_sample) + 17'(in_chan.right_sample);
  // |sum| * 23167 stays below 2^31, so the low 32 bits hold it exactly.
  assign mono_prod = pair_sum * rgsv_pkg::MONO_COEF;

  always_comb begin
    q_entry.a    = 32'(in_chan.left_sample);
    q_entry.b    = two_ch ? in_chan.right_sample : 16'sd0;
    q_entry.mode = rgsv_pkg::MODE_SINGLE;
    if (!cfg.enable) begin
      q_entry.mode = rgsv_pkg::MODE_PASS;
    end else if (two_ch && cfg.mono) begin
      q_entry.mode = rgsv_pkg::MODE_SUM;
      q_entry.a    = mono_prod[31:0];
    end else if (two_ch) begin
      q_entry.mode = rgsv_pkg::MODE_STEREO;
    end
  end

endmodule

/* sv/rgsv_queue.sv */
// ----------------------------------------------------------------------------
// Item queue
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module rgsv_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rgsv_pkg::entry_t  push_entry,
  output logic              not_full,
  input  logic              pop,
  output logic              not_empty,
  output rgsv_pkg::entry_t  head
);

  rgsv_pkg::entry_t slot_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;

  assign not_full  = (count_r != 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* sv/rgsv_back.sv */
// ----------------------------------------------------------------------------
// Back end
// Holds the gain ramp state, divides out the per-frame step, scales each
// sample with a shared 32x17 multiplier and drives the output register.
// ----------------------------------------------------------------------------
module rgsv_back #(
  parameter int FRAME_MAX = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rgsv_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  rgsv_pkg::entry_t  q_entry,
  output logic              q_pop,
  rgsv_out_if.source        out_chan
);

  // frame_len is 9 bits wide, so a cap above 511 never bites.
  localparam int FLEN_CAP_I = (FRAME_MAX > 511) ? 511 : FRAME_MAX;
  localparam logic [8:0] FLEN_CAP = 9'(FLEN_CAP_I);

  rgsv_pkg::back_state_t state_r, state_nxt;

  rgsv_pkg::entry_t   cur_r;
  logic               side_r;
  logic [31:0]        gain_r;
  logic signed [32:0] step_r;
  logic [8:0]         cnt_r;

  logic [10:0]        div_rem_r;
  logic [31:0]        div_quo_r;
  logic [9:0]         div_den_r;
  logic               div_neg_r;
  logic [4:0]         div_cnt_r;

  logic signed [63:0] acc_r;
  logic signed [35:0] rnd_r;
  logic signed [15:0] lo_r, hi_r;

  logic               out_valid_r;
  logic signed [15:0] left_out_r, right_out_r;
  logic               frame_done_r;

  logic               out_free;
  logic               out_load;

  logic [8:0]         flen;
  logic [9:0]         total;
  logic [31:0]        target;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic [10:0]        div_shift;
  logic               div_fit;
  logic signed [31:0] opnd;
  logic [15:0]        mul_g;
  logic signed [48:0] mul_p;
  logic signed [63:0] rnd_sum;
  logic signed [15:0] sat_val;
  logic signed [33:0] gain_sum;
  logic [31:0]        gain_adv;
  logic               frame_end;

  // ---------------- combinational datapath ----------------
  always_comb begin
    if (cfg.frame_len == 9'd0) begin
      flen = 9'd1;
    end else if (cfg.frame_len > FLEN_CAP) begin
      flen = FLEN_CAP;
    end else begin
      flen = cfg.frame_len;
    end
  end

  // Stereo ramps over two gain steps per item.
  assign total    = (q_entry.mode == rgsv_pkg::MODE_STEREO) ? {flen, 1'b0} : {1'b0, flen};
  assign target   = cfg.mute ? 32'd0 : {cfg.gain_linear, 16'd0};
  assign diff     = $signed({1'b0, target}) - $signed({1'b0, gain_r});
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

  assign div_shift = {div_rem_r[9:0], div_quo_r[31]};
  assign div_fit   = (div_shift >= {1'b0, div_den_r});

  assign opnd  = side_r ? 32'(cur_r.b) : cur_r.a;
  assign mul_g = (state_r == rgsv_pkg::B_MUL_HI) ? gain_r[31:16] : gain_r[15:0];
  assign mul_p = opnd * $signed({1'b0, mul_g});

  // Half an LSB, then a floor shift: 43 bits for the mono sum, 28 otherwise.
  assign rnd_sum = acc_r + ((cur_r.mode == rgsv_pkg::MODE_SUM) ? 64'sh0000_0400_0000_0000
                                                               : 64'sh0000_0000_0800_0000);

  always_comb begin
    if (rnd_r > 36'sd32767) begin
      sat_val = 16'sh7FFF;
    end else if (rnd_r < -36'sd32768) begin
      sat_val = 16'sh8000;
    end else begin
      sat_val = rnd_r[15:0];
    end
  end

  assign gain_sum = $signed({2'b00, gain_r}) + 34'(step_r);
  always_comb begin
    if (gain_sum[33]) begin
      gain_adv = 32'd0;
    end else if (gain_sum[32]) begin
      gain_adv = 32'hFFFF_FFFF;
    end else begin
      gain_adv = gain_sum[31:0];
    end
  end

  assign frame_end = ({1'b0, cnt_r} + 10'd1) >= {1'b0, flen};

  assign out_free = !out_valid_r || out_chan.ready;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rgsv_pkg::B_IDLE: begin
        if (q_valid) begin
          if (q_entry.mode == rgsv_pkg::MODE_PASS) begin
            state_nxt = rgsv_pkg::B_DONE;
          end else if (cnt_r == 9'd0) begin
            state_nxt = rgsv_pkg::B_DIV;
          end else begin
            state_nxt = rgsv_pkg::B_MUL_LO;
          end
        end
      end
      rgsv_pkg::B_DIV: begin
        if (div_cnt_r == 5'd31) begin
          state_nxt = rgsv_pkg::B_STEP;
        end
      end
      rgsv_pkg::B_STEP:   state_nxt = rgsv_pkg::B_MUL_LO;
      rgsv_pkg::B_MUL_LO: state_nxt = rgsv_pkg::B_MUL_HI;
      rgsv_pkg::B_MUL_HI: state_nxt = rgsv_pkg::B_RND;
      rgsv_pkg::B_RND:    state_nxt = rgsv_pkg::B_SAT;
      rgsv_pkg::B_SAT: begin
        if (cur_r.mode == rgsv_pkg::MODE_STEREO && !side_r) begin
          state_nxt = rgsv_pkg::B_MUL_LO;
        end else begin
          state_nxt = rgsv_pkg::B_DONE;
        end
      end
      rgsv_pkg::B_DONE: begin
        if (out_free) begin
          state_nxt = rgsv_pkg::B_IDLE;
        end
      end
      default: state_nxt = rgsv_pkg::B_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      rgsv_pkg::B_IDLE: q_pop    = q_valid;
      rgsv_pkg::B_DONE: out_load = out_free;
      default: begin
        q_pop    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rgsv_pkg::B_IDLE;
      gain_r      <= rgsv_pkg::UNITY_GAIN;
      step_r      <= 33'sd0;
      cnt_r       <= 9'd0;
      side_r      <= 1'b0;
      div_cnt_r   <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        rgsv_pkg::B_IDLE: begin
          side_r    <= 1'b0;
          div_cnt_r <= 5'd0;
        end
        rgsv_pkg::B_DIV: div_cnt_r <= div_cnt_r + 5'd1;
        rgsv_pkg::B_STEP: begin
          step_r <= div_neg_r ? -$signed({1'b0, div_quo_r}) : $signed({1'b0, div_quo_r});
        end
        rgsv_pkg::B_SAT: begin
          gain_r <= gain_adv;
          side_r <= 1'b1;
        end
        rgsv_pkg::B_DONE: begin
          // The end-of-frame snap overrides the last ramp step.
          if (out_load && cur_r.mode != rgsv_pkg::MODE_PASS) begin
            if (frame_end) begin
              gain_r <= target;
              cnt_r  <= 9'd0;
            end else begin
              cnt_r <= cnt_r + 9'd1;
            end
          end
        end
        default: side_r <= side_r;
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_entry;
    end
    case (state_r)
      rgsv_pkg::B_IDLE: begin
        div_rem_r <= 11'd0;
        div_quo_r <= diff_mag[31:0];
        div_neg_r <= diff[32];
        div_den_r <= total;
      end
      rgsv_pkg::B_DIV: begin
        if (div_fit) begin
          div_rem_r <= div_shift - {1'b0, div_den_r};
        end else begin
          div_rem_r <= div_shift;
        end
        div_quo_r <= {div_quo_r[30:0], div_fit};
      end
      rgsv_pkg::B_MUL_LO: acc_r <= 64'(mul_p);
      rgsv_pkg::B_MUL_HI: acc_r <= acc_r + {mul_p[47:0], 16'd0};
      rgsv_pkg::B_RND: begin
        if (cur_r.mode == rgsv_pkg::MODE_SUM) begin
          rnd_r <= 36'($signed(rnd_sum[63:43]));
        end else begin
          rnd_r <= rnd_sum[63:28];
        end
      end
      rgsv_pkg::B_SAT: begin
        if (side_r) begin
          hi_r <= sat_val;
        end else begin
          lo_r <= sat_val;
          hi_r <= (cur_r.mode == rgsv_pkg::MODE_SUM) ? sat_val : 16'sd0;
        end
      end
      default: acc_r <= acc_r;
    endcase

    if (out_load) begin
      if (cur_r.mode == rgsv_pkg::MODE_PASS) begin
        left_out_r   <= cur_r.a[15:0];
        right_out_r  <= cur_r.b;
        frame_done_r <= 1'b0;
      end else begin
        left_out_r   <= lo_r;
        right_out_r  <= hi_r;
        frame_done_r <= frame_end;
      end
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.left_out   = left_out_r;
  assign out_chan.right_out  = right_out_r;
  assign out_chan.frame_done = frame_done_r;

endmodule

/* sv/ramped_gain_stereo_volume.sv */
// ----------------------------------------------------------------------------
// Ramped-gain stereo volume
// Scales Q1.15 sample pairs by a gain that ramps linearly over each frame
// toward the target gain, with mute, mono sum and pass-through modes.
//
//   Channel  Direction  Handshake      Payload
//   in_chan  in         valid/ready    left_sample, right_sample
//   out_chan out        valid/ready    left_out, right_out, frame_done
//   cfg_*    in         write enable   cfg_index, cfg_wdata
//
// Each scaled item runs the back-end multiply, round and saturate states,
// twice for a stereo item; the shared 32x17 multiplier is used twice per
// scaled sample. The first scaled item of a frame also runs the bit-serial
// step division. Reset is synchronous and clears gain to unity.
// A two-entry queue lets the input keep taking transfers while the output
// stalls, and the output register holds a result until it is taken.
// ----------------------------------------------------------------------------
module ramped_gain_stereo_volume #(
  parameter int FRAME_MAX = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rgsv_in_if.sink                       in_chan,
  rgsv_out_if.source                    out_chan,
  input  logic                          cfg_we,
  input  logic [rgsv_pkg::IDX_W-1:0]    cfg_index,
  input  logic [rgsv_pkg::CFG_W-1:0]    cfg_wdata
);

  rgsv_pkg::cfg_t   cfg_r;
  rgsv_pkg::entry_t push_entry;
  rgsv_pkg::entry_t head;
  logic             push;
  logic             pop;
  logic             not_full;
  logic             not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable      <= 1'b1;
      cfg_r.mono        <= 1'b0;
      cfg_r.channels    <= 2'd2;
      cfg_r.mute        <= 1'b0;
      cfg_r.gain_linear <= 16'd4096;
      cfg_r.frame_len   <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        rgsv_pkg::REG_ENABLE:      cfg_r.enable      <= cfg_wdata[0];
        rgsv_pkg::REG_MONO:        cfg_r.mono        <= cfg_wdata[0];
        rgsv_pkg::REG_CHANNELS:    cfg_r.channels    <= cfg_wdata[1:0];
        rgsv_pkg::REG_MUTE:        cfg_r.mute        <= cfg_wdata[0];
        rgsv_pkg::REG_GAIN_LINEAR: cfg_r.gain_linear <= cfg_wdata[15:0];
        rgsv_pkg::REG_FRAME_LEN:   cfg_r.frame_len   <= cfg_wdata[8:0];
        default:                   cfg_r             <= cfg_r;
      endcase
    end
  end

  rgsv_front u_front (
    .in_chan (in_chan),
    .cfg     (cfg_r),
    .q_ready (not_full),
    .q_push  (push),
    .q_entry (push_entry)
  );

  rgsv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .not_full   (not_full),
    .pop        (pop),
    .not_empty  (not_empty),
    .head       (head)
  );

  rgsv_back #(
    .FRAME_MAX (FRAME_MAX)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (not_empty),
    .q_entry  (head),
    .q_pop    (pop),
    .out_chan (out_chan)
  );

endmodule
